FILE: rtl/i2cram_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master - shared types and constants
// Bus phase codes, action codes and the request/response item layouts.
// ----------------------------------------------------------------------------
package i2cram_pkg;

   localparam logic [7:0] ACK_RETRIES_RST = 8'd5;
   localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

   // action codes carried in tuser
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // quarter-bit slots
   localparam logic [1:0] QTR_0 = 2'd0;
   localparam logic [1:0] QTR_1 = 2'd1;
   localparam logic [1:0] QTR_2 = 2'd2;
   localparam logic [1:0] QTR_3 = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_START   = 4'd1,
      PH_ADDRW   = 4'd2,
      PH_ACKAW   = 4'd3,
      PH_REG     = 4'd4,
      PH_ACKREG  = 4'd5,
      PH_RESTART = 4'd6,
      PH_ADDRR   = 4'd7,
      PH_ACKAR   = 4'd8,
      PH_TX      = 4'd9,
      PH_ACKTX   = 4'd10,
      PH_RX      = 4'd11,
      PH_MACK    = 4'd12,
      PH_STOP    = 4'd13,
      PH_STOPERR = 4'd14
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] device_addr;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       write_taken;
      logic       last_byte;
      logic       busy_res;
      logic       done_res;
      logic       status;
   } rsp_item_type;

endpackage
`default_nettype wire

FILE: rtl/i2cram_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master - bus sequencer
// Holds the bus state, starts a transfer on a begin item and advances it by one quarter bit per stepped tick item.
// ----------------------------------------------------------------------------
module i2cram_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step_en,
   input  wire i2cram_pkg::req_item_type item,
   input  wire logic [7:0]              ack_retries,
   output      i2cram_pkg::rsp_item_type rsp
);
   import i2cram_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] quarter_ff, quarter_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] bytes_ff, bytes_in;
   logic [7:0] retry_ff, retry_in;
   logic [6:0] device_ff, device_in;
   logic [7:0] register_ff, register_in;
   logic       is_read_ff, is_read_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;

   logic [3:0] bit_inc;
   logic [7:0] bytes_dec;
   logic [7:0] retry_dec;
   logic       last_left;
   logic [7:0] rbyte;
   logic       rvalid, wtaken, last, done, stat;

   assign bit_inc   = bit_ff + 4'd1;
   assign bytes_dec = bytes_ff - 8'd1;
   assign retry_dec = retry_ff - 8'd1;
   assign last_left = (bytes_ff <= 8'd1);

   always_comb begin
      phase_in    = phase_ff;
      quarter_in  = quarter_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      bytes_in    = bytes_ff;
      retry_in    = retry_ff;
      device_in   = device_ff;
      register_in = register_ff;
      is_read_in  = is_read_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      rbyte       = 8'd0;
      rvalid      = 1'b0;
      wtaken      = 1'b0;
      last        = 1'b0;
      done        = 1'b0;
      stat        = 1'b0;

      if (step_en) begin
         // unused action code and tick while idle fall through untouched
         if (item.action == ACT_WRITE || item.action == ACT_READ) begin
            if (phase_ff == PH_IDLE) begin
               device_in   = item.device_addr;
               register_in = item.reg_addr;
               bytes_in    = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
               is_read_in  = (item.action == ACT_READ);
               phase_in    = PH_START;
               quarter_in  = QTR_0;
               bit_in      = 4'd0;
            end
         end else if (item.action == ACT_TICK && phase_ff != PH_IDLE) begin
            quarter_in = quarter_ff + 2'd1;
            unique case (phase_ff)
               PH_START, PH_RESTART: begin
                  unique case (quarter_ff)
                     QTR_0: sda_in = 1'b1;
                     QTR_1: scl_in = 1'b1;
                     QTR_2: sda_in = 1'b0;
                     QTR_3: begin
                        scl_in   = 1'b0;
                        bit_in   = 4'd0;
                        phase_in = (phase_ff == PH_START) ? PH_ADDRW : PH_ADDRR;
                     end
                     default: ;
                  endcase
               end
               PH_ADDRW, PH_REG, PH_ADDRR, PH_TX: begin
                  unique case (quarter_ff)
                     QTR_0: begin
                        if (bit_ff == 4'd0) begin
                           unique case (phase_ff)
                              PH_ADDRW: shift_in = {device_ff, 1'b0};
                              PH_REG:   shift_in = register_ff;
                              PH_ADDRR: shift_in = {device_ff, 1'b1};
                              default: begin
                                 shift_in = item.write_byte;
                                 wtaken   = 1'b1;
                                 last     = last_left;
                              end
                           endcase
                        end
                        scl_in = 1'b0;
                        sda_in = shift_in[7];
                     end
                     QTR_1: ;
                     QTR_2: scl_in = 1'b1;
                     QTR_3: begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        bit_in   = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                           bit_in = 4'd0;
                           unique case (phase_ff)
                              PH_ADDRW: phase_in = PH_ACKAW;
                              PH_REG:   phase_in = PH_ACKREG;
                              PH_ADDRR: phase_in = PH_ACKAR;
                              default:  phase_in = PH_ACKTX;
                           endcase
                        end
                     end
                     default: ;
                  endcase
               end
               PH_ACKAW, PH_ACKREG, PH_ACKAR, PH_ACKTX: begin
                  priority if (quarter_ff == QTR_0) begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     retry_in = (ack_retries == 8'd0) ? 8'd1 : ack_retries;
                  end else if (quarter_ff == QTR_1) begin
                     scl_in = 1'b1;
                  end else begin
                     // keep sampling in the high half until acked or out of retries
                     quarter_in = QTR_2;
                     if (!item.sda_in) begin
                        quarter_in = QTR_0;
                        unique case (phase_ff)
                           PH_ACKAW:  phase_in = PH_REG;
                           PH_ACKREG: phase_in = is_read_ff ? PH_RESTART : PH_TX;
                           PH_ACKAR:  phase_in = PH_RX;
                           default: begin
                              bytes_in = bytes_dec;
                              phase_in = (bytes_dec == 8'd0) ? PH_STOP : PH_TX;
                           end
                        endcase
                     end else begin
                        retry_in = retry_dec;
                        if (retry_dec == 8'd0) begin
                           phase_in   = PH_STOPERR;
                           quarter_in = QTR_0;
                        end
                     end
                  end
               end
               PH_RX: begin
                  unique case (quarter_ff)
                     QTR_0: begin
                        scl_in = 1'b0;
                        sda_in = 1'b1;
                        if (bit_ff == 4'd0) begin
                           shift_in = 8'd0;
                        end
                     end
                     QTR_1: ;
                     QTR_2: scl_in = 1'b1;
                     QTR_3: begin
                        shift_in = {shift_ff[6:0], item.sda_in};
                        bit_in   = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                           bit_in   = 4'd0;
                           rbyte    = shift_in;
                           rvalid   = 1'b1;
                           last     = last_left;
                           phase_in = PH_MACK;
                        end
                     end
                     default: ;
                  endcase
               end
               PH_MACK: begin
                  unique case (quarter_ff)
                     QTR_0: begin
                        scl_in = 1'b0;
                        sda_in = last_left;   // NACK the final byte
                     end
                     QTR_1: ;
                     QTR_2: scl_in = 1'b1;
                     QTR_3: begin
                        if (bytes_ff != 8'd0) begin
                           bytes_in = bytes_dec;
                        end
                        phase_in = (bytes_ff <= 8'd1) ? PH_STOP : PH_RX;
                     end
                     default: ;
                  endcase
               end
               PH_STOP, PH_STOPERR: begin
                  unique case (quarter_ff)
                     QTR_0: scl_in = 1'b0;
                     QTR_1: sda_in = 1'b0;
                     QTR_2: scl_in = 1'b1;
                     QTR_3: begin
                        sda_in   = 1'b1;
                        done     = 1'b1;
                        stat     = (phase_ff == PH_STOPERR);
                        phase_in = PH_IDLE;
                     end
                     default: ;
                  endcase
               end
               default: begin
                  phase_in   = PH_IDLE;
                  quarter_in = quarter_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp.scl_level   = scl_in;
      rsp.sda_release = sda_in;
      rsp.read_byte   = rbyte;
      rsp.read_valid  = rvalid;
      rsp.write_taken = wtaken;
      rsp.last_byte   = last;
      rsp.busy_res    = (phase_in != PH_IDLE);
      rsp.done_res    = done;
      rsp.status      = stat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         quarter_ff  <= QTR_0;
         bit_ff      <= 4'd0;
         shift_ff    <= 8'd0;
         bytes_ff    <= 8'd0;
         retry_ff    <= 8'd0;
         device_ff   <= 7'd0;
         register_ff <= 8'd0;
         is_read_ff  <= 1'b0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         quarter_ff  <= quarter_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         bytes_ff    <= bytes_in;
         retry_ff    <= retry_in;
         device_ff   <= device_in;
         register_ff <= register_in;
         is_read_ff  <= is_read_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/i2c_register_access_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master
// Open-drain I2C master stepped one quarter bit per tick request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per action. tuser is the action (tick, begin
//            write, begin read); tdata carries the transfer operands, the next
//            write byte and the sampled SDA level.
//   rsp_*  : exactly one response per request: line drives after the step,
//            read/write byte events, busy, done and status. tlast flags the
//            final data byte of the transfer.
//   csr_*  : ack_retries, always ready; write it only while idle.
// Path: an accepted request is held in the input register, stepped through the
//   sequencer when the response register is free or being read, and registered there.
// Throughput: one transaction per cycle while rsp_tready does not stall; the
//   sequencer step lies between the input register and the response register.
// Reset: bus idle, SCL and SDA released, ack_retries back to 5, both
//   registers empty. A stalled rsp_tready holds the response and backs up
//   into req_tready once the input register is also full.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
   input  wire logic        clock,
   input  wire logic        reset,
   // device_addr[6:0], reg_addr[7:0], byte_count[7:0], write_byte[7:0], sda_in
   input  wire logic [31:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // scl_level, sda_release, read_byte[7:0], read_valid, write_taken,
   // busy_res, done_res, status, one zero pad bit
   output      logic [15:0] rsp_tdata,
   output      logic        rsp_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  csr_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready
);
   import i2cram_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic [7:0]   ack_retries_ff, ack_retries_in;
   logic         step_en;
   logic         req_fire;

   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_item_in.action      = req_tuser;
      in_item_in.device_addr = req_tdata[6:0];
      in_item_in.reg_addr    = req_tdata[14:7];
      in_item_in.byte_count  = req_tdata[22:15];
      in_item_in.write_byte  = req_tdata[30:23];
      in_item_in.sda_in      = req_tdata[31];
      in_valid_in            = req_fire || (in_valid_ff && !step_en);
      out_valid_in           = step_en || (out_valid_ff && !rsp_tready);
      ack_retries_in         = (csr_valid && csr_ready) ? csr_data : ack_retries_ff;
   end

   i2cram_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .item        (in_item_ff),
      .ack_retries (ack_retries_ff),
      .rsp         (out_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         ack_retries_ff <= ACK_RETRIES_RST;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         ack_retries_ff <= ack_retries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      if (step_en) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_item_ff.last_byte;
   assign rsp_tdata  = {1'b0,
                        out_item_ff.status,
                        out_item_ff.done_res,
                        out_item_ff.busy_res,
                        out_item_ff.write_taken,
                        out_item_ff.read_valid,
                        out_item_ff.read_byte,
                        out_item_ff.sda_release,
                        out_item_ff.scl_level};

endmodule
`default_nettype wire

FILE: rtl/i2cram_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C register access master - port checker
// Watches the response stream for consistency of the reported events.
// ----------------------------------------------------------------------------
module i2cram_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   // a stalled response must hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // error status only comes with the STOP completing
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> rsp_tdata[13])
      else $error("status without done");

   // a finished STOP leaves the bus idle and both lines released
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> !rsp_tdata[12] && rsp_tdata[0] && rsp_tdata[1])
      else $error("done with bus not released");

   // a byte is either received or taken for sending, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[10] && rsp_tdata[11]))
      else $error("read and write event together");

   // last-byte flag only accompanies a byte event
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[10] || rsp_tdata[11])
      else $error("last flag without byte event");

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master - self-checking bench
// Drives quarter-bit actions from a small target model and checks every
// response against a local predictor of the bus sequencer or a directed table row.
// Checking covers line drives, byte events, busy, done and status under
// several ACK retry limits and random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   import i2cram_pkg::*;

   localparam logic [1:0] ACT_NOP     = 2'd3;
   localparam int         PHASES      = 6;
   localparam int         PHASE_ITEMS = 320;
   localparam int         DIR_ROWS    = 24;

   typedef struct packed {
      logic [1:0] act;
      logic [6:0] dev;
      logic [7:0] regn;
      logic [7:0] cnt;
      logic [7:0] wbyte;
      logic       sda;
      logic       typed;
      logic       tscl;
      logic       tsda;
      logic       tbusy;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = ACT_TICK;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  csr_data   = '0;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;

   // bus sequencer as the bench sees it
   phase_type   bus_ph      = PH_IDLE;
   logic [1:0]  qtr         = QTR_0;
   logic [3:0]  nbits       = '0;
   logic [7:0]  shreg       = '0;
   logic [7:0]  bytes_rem   = '0;
   logic [7:0]  retries_rem = '0;
   logic [6:0]  dev_h       = '0;
   logic [7:0]  reg_h       = '0;
   logic        dir_read    = 1'b0;
   logic        scl_drv     = 1'b1;
   logic        sda_drv     = 1'b1;
   logic [7:0]  retry_limit = ACK_RETRIES_RST;

   rsp_item_type pending_rsp [$];
   int           error_count = 0;
   int           sent        = 0;
   bit           choppy      = 1'b1;
   bit           calm        = 1'b0;

   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{ACT_NOP,   7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{ACT_TICK,  7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      // count of zero runs as a single byte
      '{ACT_WRITE, 7'h7F, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
      // begin while busy is dropped
      '{ACT_READ,  7'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      '{ACT_NOP,   7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
      '{ACT_TICK,  7'h55, 8'hAA, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h2A, 8'h55, 8'h02, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_WRITE, 7'h11, 8'h22, 8'h03, 8'h44, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_NOP,   7'h3C, 8'hC3, 8'h80, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_TICK,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
   };

   i2c_register_access_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #1 clock = ~clock;

   // one quarter-bit step of the sequencer
   function automatic rsp_item_type step_bus(input req_item_type it);
      rsp_item_type r;
      logic [1:0]   nq;
      phase_type    ph;
      r  = '0;
      ph = bus_ph;
      if (it.action == ACT_WRITE || it.action == ACT_READ) begin
         if (ph == PH_IDLE) begin
            dev_h     = it.device_addr;
            reg_h     = it.reg_addr;
            bytes_rem = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
            dir_read  = (it.action == ACT_READ);
            bus_ph    = PH_START;
            qtr       = QTR_0;
            nbits     = '0;
         end
      end else if (it.action == ACT_TICK && ph != PH_IDLE) begin
         nq = qtr + 2'd1;
         case (ph)
            PH_START, PH_RESTART: begin
               case (qtr)
                  QTR_0: sda_drv = 1'b1;
                  QTR_1: scl_drv = 1'b1;
                  QTR_2: sda_drv = 1'b0;
                  default: begin
                     scl_drv = 1'b0;
                     bus_ph  = (ph == PH_START) ? PH_ADDRW : PH_ADDRR;
                     nbits   = '0;
                  end
               endcase
            end
            PH_ADDRW, PH_REG, PH_ADDRR, PH_TX: begin
               if (qtr == QTR_0 && nbits == 4'd0) begin
                  case (ph)
                     PH_ADDRW: shreg = {dev_h, 1'b0};
                     PH_REG:   shreg = reg_h;
                     PH_ADDRR: shreg = {dev_h, 1'b1};
                     default: begin
                        shreg         = it.write_byte;
                        r.write_taken = 1'b1;
                        r.last_byte   = (bytes_rem <= 8'd1);
                     end
                  endcase
               end
               if (qtr == QTR_0) begin
                  scl_drv = 1'b0;
                  sda_drv = shreg[7];
               end else if (qtr == QTR_2) begin
                  scl_drv = 1'b1;
               end else if (qtr == QTR_3) begin
                  shreg = shreg << 1;
                  nbits = nbits + 4'd1;
                  if (nbits >= BITS_PER_BYTE) begin
                     nbits  = '0;
                     bus_ph = phase_type'(ph + 4'd1);
                  end
               end
            end
            PH_ACKAW, PH_ACKREG, PH_ACKAR, PH_ACKTX: begin
               if (qtr == QTR_0) begin
                  scl_drv     = 1'b0;
                  sda_drv     = 1'b1;
                  retries_rem = (retry_limit == 8'd0) ? 8'd1 : retry_limit;
               end else if (qtr == QTR_1) begin
                  scl_drv = 1'b1;
               end else begin
                  // keeps sampling in the high half until ACK or timeout
                  nq = QTR_2;
                  if (!it.sda_in) begin
                     nq = QTR_0;
                     case (ph)
                        PH_ACKAW:  bus_ph = PH_REG;
                        PH_ACKREG: bus_ph = dir_read ? PH_RESTART : PH_TX;
                        PH_ACKAR:  bus_ph = PH_RX;
                        default: begin
                           bytes_rem = bytes_rem - 8'd1;
                           bus_ph    = (bytes_rem == 8'd0) ? PH_STOP : PH_TX;
                        end
                     endcase
                  end else begin
                     retries_rem = retries_rem - 8'd1;
                     if (retries_rem == 8'd0) begin
                        bus_ph = PH_STOPERR;
                        nq     = QTR_0;
                     end
                  end
               end
            end
            PH_RX: begin
               if (qtr == QTR_0) begin
                  scl_drv = 1'b0;
                  sda_drv = 1'b1;
                  if (nbits == 4'd0) shreg = '0;
               end else if (qtr == QTR_2) begin
                  scl_drv = 1'b1;
               end else if (qtr == QTR_3) begin
                  shreg = {shreg[6:0], it.sda_in};
                  nbits = nbits + 4'd1;
                  if (nbits >= BITS_PER_BYTE) begin
                     nbits        = '0;
                     r.read_byte  = shreg;
                     r.read_valid = 1'b1;
                     r.last_byte  = (bytes_rem <= 8'd1);
                     bus_ph       = PH_MACK;
                  end
               end
            end
            PH_MACK: begin
               if (qtr == QTR_0) begin
                  scl_drv = 1'b0;
                  sda_drv = (bytes_rem <= 8'd1);
               end else if (qtr == QTR_2) begin
                  scl_drv = 1'b1;
               end else if (qtr == QTR_3) begin
                  if (bytes_rem != 8'd0) bytes_rem = bytes_rem - 8'd1;
                  bus_ph = (bytes_rem == 8'd0) ? PH_STOP : PH_RX;
               end
            end
            default: begin
               case (qtr)
                  QTR_0: scl_drv = 1'b0;
                  QTR_1: sda_drv = 1'b0;
                  QTR_2: scl_drv = 1'b1;
                  default: begin
                     sda_drv    = 1'b1;
                     r.done_res = 1'b1;
                     r.status   = (ph == PH_STOPERR);
                     bus_ph     = PH_IDLE;
                  end
               endcase
            end
         endcase
         qtr = nq;
      end
      r.scl_level   = scl_drv;
      r.sda_release = sda_drv;
      r.busy_res    = (bus_ph != PH_IDLE);
      return r;
   endfunction

   // next action from a loosely cooperative target
   function automatic req_item_type next_req(input int ack_pct);
      req_item_type it;
      int           roll;
      it.device_addr = 7'($urandom);
      it.reg_addr    = 8'($urandom);
      it.byte_count  = 8'($urandom);
      it.write_byte  = 8'($urandom);
      it.sda_in      = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (bus_ph == PH_IDLE) begin
         if (roll < 6) begin
            it.action = ACT_TICK;
         end else if (roll < 10) begin
            it.action = ACT_NOP;
         end else begin
            it.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
            roll = $urandom_range(0, 99);
            if (roll < 5)
               it.byte_count = 8'd0;
            else if (roll < 15 && it.action == ACT_WRITE)
               it.byte_count = 8'($urandom_range(5, 255));
            else
               it.byte_count = 8'($urandom_range(1, 3));
         end
      end else begin
         if (roll < 3)
            it.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
         else if (roll < 5)
            it.action = ACT_NOP;
         else
            it.action = ACT_TICK;
         if ((bus_ph == PH_ACKAW || bus_ph == PH_ACKREG || bus_ph == PH_ACKAR ||
              bus_ph == PH_ACKTX) && qtr >= QTR_2) begin
            // long writes get refused on the first data byte
            if (bus_ph == PH_ACKTX && bytes_rem > 8'd4)
               it.sda_in = 1'b1;
            else
               it.sda_in = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
         end
      end
      return it;
   endfunction

   function automatic string fmt_rsp(input rsp_item_type r);
      return $sformatf("scl=%b sda=%b rbyte=%h rvalid=%b wtaken=%b last=%b busy=%b done=%b st=%b",
                       r.scl_level, r.sda_release, r.read_byte, r.read_valid,
                       r.write_taken, r.last_byte, r.busy_res, r.done_res, r.status);
   endfunction

   task automatic maybe_pause();
      int n;
      if (!calm && choppy && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_req(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type predicted;
      req_tdata  <= {it.sda_in, it.write_byte, it.byte_count, it.reg_addr, it.device_addr};
      req_tuser  <= it.action;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = step_bus(it);
      pending_rsp.push_back(typed ? want : predicted);
      sent++;
      if (sent % 64 == 0) choppy = ($urandom_range(0, 2) != 0);
   endtask

   task automatic write_retry_limit(input logic [7:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      retry_limit = value;
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      dir_row_type  row;
      req_item_type it;
      rsp_item_type want;
      logic [7:0]   limit_val;
      int           used;
      int           ack_pct;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row            = dir_rows[i];
         it.action      = row.act;
         it.device_addr = row.dev;
         it.reg_addr    = row.regn;
         it.byte_count  = row.cnt;
         it.write_byte  = row.wbyte;
         it.sda_in      = row.sda;
         want             = '0;
         want.scl_level   = row.tscl;
         want.sda_release = row.tsda;
         want.busy_res    = row.tbusy;
         maybe_pause();
         send_req(it, row.typed, want);
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            // retry limit only changes with the bus idle and nothing in flight
            req_tvalid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
            case (p)
               1: limit_val = 8'd1;
               2: limit_val = 8'd255;
               3: limit_val = 8'd0;
               4: limit_val = 8'($urandom_range(2, 254));
               default: limit_val = ACK_RETRIES_RST;
            endcase
            write_retry_limit(limit_val);
         end
         calm    = (p == PHASES - 1);
         ack_pct = (retry_limit <= 8'd1) ? 85 : 70;
         used    = 0;
         while (!(bus_ph == PH_IDLE && used >= PHASE_ITEMS)) begin
            it = next_req(ack_pct);
            if ((bus_ph == PH_IDLE) ? (it.action == ACT_WRITE || it.action == ACT_READ)
                                    : (it.action == ACT_TICK))
               used++;
            maybe_pause();
            send_req(it, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin : rsp_stall
      int n;
      int cyc;
      bit stall_mode;
      cyc        = 0;
      stall_mode = 1'b1;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 200 == 0) stall_mode = ($urandom_range(0, 2) != 0);
         if (!calm && stall_mode && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            cyc += n;
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen             = '0;
         seen.scl_level   = rsp_tdata[0];
         seen.sda_release = rsp_tdata[1];
         seen.read_byte   = rsp_tdata[9:2];
         seen.read_valid  = rsp_tdata[10];
         seen.write_taken = rsp_tdata[11];
         seen.busy_res    = rsp_tdata[12];
         seen.done_res    = rsp_tdata[13];
         seen.status      = rsp_tdata[14];
         seen.last_byte   = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            if (error_count < 10)
               $display("%0t unexpected response transaction: %s", $time, fmt_rsp(seen));
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (seen !== want) begin
               if (error_count < 10)
                  $display("%0t response mismatch\n   exp %s\n   got %s",
                           $time, fmt_rsp(want), fmt_rsp(seen));
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #1000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
